>>> design/prq_pkg.sv
// Shared types, widths and codes for the priority ready queue.
`default_nettype none

package prq_pkg;

  // Field widths; the counts of processes and levels follow from them.
  localparam int PROC_W      = 4;
  localparam int LEVEL_W     = 3;
  localparam int PROC_COUNT  = 1 << PROC_W;
  localparam int LEVEL_COUNT = 1 << LEVEL_W;

  // Operation codes.
  localparam logic [1:0] OP_TAIL = 2'd0;
  localparam logic [1:0] OP_HEAD = 2'd1;
  localparam logic [1:0] OP_DEQ  = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BLOCKED   = 2'd1;
  localparam logic [1:0] ST_DUPLICATE = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // One request.
  typedef struct packed {
    logic [1:0]         operation;
    logic [PROC_W-1:0]  proc_id;
    logic [LEVEL_W-1:0] prio;
    logic               blocked;
  } prq_in_t;

  // One result.
  typedef struct packed {
    logic [1:0]        status;
    logic [PROC_W-1:0] chosen_proc;
    logic              chosen_valid;
  } prq_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic look;
    logic commit;
  } prq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } prq_sts_t;

endpackage

`default_nettype wire

>>> design/prq_ctrl.sv
// Controller state machine for the priority ready queue.
`default_nettype none

module prq_ctrl
  import prq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire prq_sts_t sts,
  output prq_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // The queue takes a new request only when no request is in flight.
  assign in_ready = (state_r == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.look    = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/prq_dp.sv
// Datapath of the priority ready queue: linked lists, level flags and result register.
`default_nettype none

module prq_dp
  import prq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire prq_in_t  in_data,
  input  wire prq_cmd_t cmd,
  output prq_sts_t      sts,
  output logic          out_valid,
  input  wire logic     out_ready,
  output prq_out_t      out_data
);

  // Captured request and lookup results.
  prq_in_t            req_r;
  logic [LEVEL_W-1:0] lvl_r;
  logic [PROC_W-1:0]  head_r;
  logic [PROC_W-1:0]  tail_r;
  logic [PROC_W-1:0]  succ_r;
  logic               hit_r;
  logic               dup_r;

  // Queue state.
  logic [PROC_W-1:0]      next_link_r  [PROC_COUNT];
  logic [PROC_W-1:0]      level_head_r [LEVEL_COUNT];
  logic [PROC_W-1:0]      level_tail_r [LEVEL_COUNT];
  logic [LEVEL_COUNT-1:0] level_nonempty_r, level_nonempty_nxt;
  logic [PROC_COUNT-1:0]  in_queue_r, in_queue_nxt;

  // Result register.
  logic     out_valid_r;
  prq_out_t out_data_r;
  prq_out_t res;

  // Lookup signals.
  logic [LEVEL_W-1:0] enc;
  logic [LEVEL_W-1:0] lvl_sel;

  // Update signals.
  logic              nl_we;
  logic [PROC_W-1:0] nl_addr;
  logic [PROC_W-1:0] nl_wdata;
  logic              lh_we;
  logic [PROC_W-1:0] lh_wdata;
  logic              lt_we;
  logic [PROC_W-1:0] lt_wdata;
  logic              is_deq;
  logic              is_enq;

  assign is_deq = (req_r.operation == OP_DEQ);
  assign is_enq = (req_r.operation == OP_TAIL) || (req_r.operation == OP_HEAD);

  // Most urgent nonempty level: lowest set bit.
  always_comb begin
    enc = '0;
    for (int i = LEVEL_COUNT - 1; i >= 0; i--) begin
      if (level_nonempty_r[i]) begin
        enc = LEVEL_W'(i);
      end
    end
  end

  assign lvl_sel = is_deq ? enc : req_r.prio;

  // Request capture and lookup of the chosen level and the link behind its head.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data;
    end
    if (cmd.look) begin
      lvl_r  <= lvl_sel;
      head_r <= level_head_r[lvl_sel];
      tail_r <= level_tail_r[lvl_sel];
      succ_r <= next_link_r[level_head_r[lvl_sel]];
      hit_r  <= level_nonempty_r[lvl_sel];
      dup_r  <= in_queue_r[req_r.proc_id];
    end
  end

  // List update and result of the request.
  always_comb begin
    level_nonempty_nxt = level_nonempty_r;
    in_queue_nxt       = in_queue_r;
    nl_we              = 1'b0;
    nl_addr            = tail_r;
    nl_wdata           = req_r.proc_id;
    lh_we              = 1'b0;
    lh_wdata           = req_r.proc_id;
    lt_we              = 1'b0;
    lt_wdata           = req_r.proc_id;
    res.status         = ST_OK;
    res.chosen_proc    = '0;
    res.chosen_valid   = 1'b0;
    if (is_deq) begin
      if (!hit_r) begin
        res.status = ST_EMPTY;
      end else begin
        if (head_r == tail_r) begin
          level_nonempty_nxt[lvl_r] = 1'b0;
        end else begin
          lh_we    = 1'b1;
          lh_wdata = succ_r;
        end
        in_queue_nxt[head_r] = 1'b0;
        res.chosen_proc      = head_r;
        res.chosen_valid     = 1'b1;
      end
    end else if (is_enq) begin
      if (req_r.blocked) begin
        res.status = ST_BLOCKED;
      end else if (dup_r) begin
        res.status = ST_DUPLICATE;
      end else begin
        if (!hit_r) begin
          // First process of an empty level is both head and tail.
          lh_we                     = 1'b1;
          lt_we                     = 1'b1;
          level_nonempty_nxt[lvl_r] = 1'b1;
        end else if (req_r.operation == OP_TAIL) begin
          nl_we = 1'b1;
          lt_we = 1'b1;
        end else begin
          nl_we    = 1'b1;
          nl_addr  = req_r.proc_id;
          nl_wdata = head_r;
          lh_we    = 1'b1;
        end
        in_queue_nxt[req_r.proc_id] = 1'b1;
      end
    end
  end

  // Link and level pointer stores.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (nl_we) begin
        next_link_r[nl_addr] <= nl_wdata;
      end
      if (lh_we) begin
        level_head_r[lvl_r] <= lh_wdata;
      end
      if (lt_we) begin
        level_tail_r[lvl_r] <= lt_wdata;
      end
    end
  end

  // Occupancy flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_nonempty_r <= '0;
      in_queue_r       <= '0;
    end else if (cmd.commit) begin
      level_nonempty_r <= level_nonempty_nxt;
      in_queue_r       <= in_queue_nxt;
    end
  end

  // Output register: holds a result until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= res;
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

  // A dequeued process is no longer marked queued.
  a_deq_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && is_deq && hit_r) |=> !in_queue_r[$past(head_r)])
    else $error("dequeued process still marked queued");

  // An accepted enqueue marks the process queued.
  a_enq_sets: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && is_enq && !req_r.blocked && !dup_r)
      |=> in_queue_r[$past(req_r.proc_id)])
    else $error("enqueued process not marked queued");

  // With every level empty no process can be queued.
  a_empty_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (level_nonempty_r == '0) |-> (in_queue_r == '0))
    else $error("queued process with all levels empty");

  // A chosen process is only reported with an ok status.
  a_chosen_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r.chosen_valid || out_data_r.status == ST_OK))
    else $error("chosen process reported with a failing status");

endmodule

`default_nettype wire

>>> design/priority_ready_queue.sv
// Top level of the priority ready queue: controller and datapath.
//
//   Channel   Handshake             Payload
//   request   in_valid / in_ready   in_data   (prq_in_t: operation, proc_id, prio, blocked)
//   result    out_valid / out_ready out_data  (prq_out_t: status, chosen_proc, chosen_valid)
//
// Each request passes through capture, lookup of the chosen level's head, tail
// and the link behind the head, and update, which also loads the result register.
// A new request is taken once the update commits.
// A waiting result does not stop a new request from being taken; a second
// result waits in the update step until the first is taken.
// Synchronous reset clears all levels and queued marks; no clearing pass is needed.
`default_nettype none

module priority_ready_queue
  import prq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire prq_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output prq_out_t     out_data
);

  prq_cmd_t cmd;
  prq_sts_t sts;

  // Sequencer.
  prq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Queue storage and result register.
  prq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
